@@ design/bstk_pkg.sv @@
// Package for the bounded stack with search: payload structs, operation
// and status codes, and the default stack depth. No dependencies.
package bstk_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 255;

   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned COUNT_W  = 8;

   localparam logic [FUNC_W-1:0] OP_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] OP_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] OP_FIND = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

endpackage

@@ design/bounded_stack_with_search_core.sv @@
// Top level of the bounded stack with search: control sequencer, fill count
// and result register. Depends on bstk_pkg and bstk_ram.
//
// Usage: each request transfer carries an operation (push, pop or find) and
// a 32-bit word. Every request produces exactly one response transfer with a
// status, a position and the number of entries held after the operation.
// Push, pop and the unused operation code finish at once: the response is
// valid in the cycle after the request transfer. Find scans the stored
// words from the bottom, one word per cycle through the single read port of
// the word memory and one shared 32-bit comparator. A find stops at the
// first match or after the last stored word, and its result passes through
// a response state into the output register; with no entries the scan is
// skipped. The scan is the rate-setting loop, and only one request is in
// the block at a time.
// The response sits in an output register. A new request is taken while the
// block is idle and that register is empty or being drained in the same
// cycle, so a stalled receiver holds back the request side as well.
// Reset clears the fill count, the sequencer and the response valid. The
// word memory is not cleared: only entries below the fill count are ever
// read, and each of those was written by a push.
module bounded_stack_with_search_core #(
   parameter int unsigned CAPACITY = bstk_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bstk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bstk_pkg::rsp_type rsp_data
);
   import bstk_pkg::*;

   // Fill count holds 0..CAPACITY; a memory address holds 0..CAPACITY-1.
   localparam int unsigned FW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [FW-1:0] CAP_FW = FW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [FW-1:0]     fill_count_ff, fill_count_in;
   logic [FW-1:0]     cmp_ptr_ff, cmp_ptr_in;
   logic [WORD_W-1:0] key_ff, key_in;
   rsp_type           hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              out_free;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   // The output register may be loaded when it is empty or drains this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;

   bstk_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic [FW+7:0] count_wide;
      logic [FW+7:0] ptr_wide;
      logic [FW-1:0] ptr_next;

      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      cmp_ptr_in    = cmp_ptr_ff;
      key_in        = key_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_count_ff[AW-1:0];
      wr_data       = req_data.value;
      rd_addr       = '0;
      ptr_wide      = {8'd0, cmp_ptr_ff};
      ptr_next      = cmp_ptr_ff + FW'(1);
      count_wide    = {8'd0, fill_count_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_data_in.status = ST_OK;
               rsp_data_in.index  = '0;
               unique case (req_data.func)
                  OP_PUSH: begin
                     if (fill_count_ff == CAP_FW) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        fill_count_in = fill_count_ff + FW'(1);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_POP: begin
                     if (fill_count_ff == '0) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        fill_count_in = fill_count_ff - FW'(1);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_FIND: begin
                     key_in       = req_data.value;
                     cmp_ptr_in   = '0;
                     hold_in.status = ST_NOT_FOUND;
                     hold_in.index  = '0;
                     hold_in.count  = count_wide[7:0];
                     // Word 0 is fetched now and compared in the next cycle.
                     if (fill_count_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               count_wide        = {8'd0, fill_count_in};
               rsp_data_in.count = count_wide[7:0];
            end
         end
         S_SCAN: begin
            if (rd_data == key_ff) begin
               hold_in.status = ST_OK;
               hold_in.index  = ptr_wide[7:0];
               state_in       = S_RESP;
            end else if (ptr_next == fill_count_ff) begin
               state_in = S_RESP;
            end else begin
               cmp_ptr_in = ptr_next;
               rd_addr    = ptr_next[AW-1:0];
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ptr_ff  <= cmp_ptr_in;
      key_ff      <= key_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The fill count never exceeds the stack depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CAP_FW)
      else $error("fill count above capacity");

   // The scan only looks at positions that hold a pushed word.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cmp_ptr_ff < fill_count_ff))
      else $error("scan pointer beyond fill count");

   // The fill count moves only in the cycle after a request transfer.
   a_fill_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(fill_count_ff))
      else $error("fill count changed without a request");

   // An accepted find never answers in the very next cycle.
   a_find_waits: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.func == OP_FIND)) |=> !rsp_valid_ff)
      else $error("find answered without scanning");

endmodule

@@ design/bstk_ram.sv @@
// Word storage for the stack: one write port and one read port with
// registered read data. Depends on bstk_pkg for the word width.
module bstk_ram #(
   parameter int unsigned DEPTH = bstk_pkg::CAPACITY_DEFAULT,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [bstk_pkg::WORD_W-1:0]   wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [bstk_pkg::WORD_W-1:0]   rd_data
);
   import bstk_pkg::*;

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/stack_response_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the bounded stack with search: keeps its own copy of
// the stack, predicts each response and compares it. Depends on bstk_pkg.
module stack_response_checker #(
   parameter int unsigned CAPACITY = bstk_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  bstk_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  bstk_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                outstanding,
   output int                checked
);
   import bstk_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [WORD_W-1:0] model_words [0:CAPACITY-1];
   int                model_fill = 0;
   rsp_type           pending_stack_results [$];
   int                bad_count = 0;
   int                waiting_count = 0;
   int                seen_count = 0;

   assign mismatches  = bad_count;
   assign outstanding = waiting_count;
   assign checked     = seen_count;

   // Applies one operation to the shadow stack and returns the response
   // that the block must give for it.
   function automatic rsp_type apply_stack_op(input req_type r);
      rsp_type res;
      bit      hit;
      int      i;
      res.status = ST_OK;
      res.index  = '0;
      hit        = 1'b0;
      case (r.func)
         OP_PUSH: begin
            if (model_fill >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               model_words[model_fill] = r.value;
               model_fill++;
            end
         end
         OP_POP: begin
            if (model_fill == 0) res.status = ST_EMPTY;
            else model_fill--;
         end
         OP_FIND: begin
            res.status = ST_NOT_FOUND;
            for (i = 0; i < model_fill && !hit; i++) begin
               if (model_words[i] == r.value) begin
                  hit        = 1'b1;
                  res.status = ST_OK;
                  res.index  = i[INDEX_W-1:0];
               end
            end
         end
         default: ;
      endcase
      res.count = model_fill[COUNT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         model_fill = 0;
         pending_stack_results.delete();
      end else begin
         // The response side is handled first, so a response arriving in the
         // same cycle as a new request is matched against older requests.
         if (rsp_valid && !rsp_stall) begin
            seen_count++;
            if (pending_stack_results.size() == 0) begin
               bad_count++;
               if (bad_count <= REPORT_LIMIT)
                  $display("[%0t] unexpected response: status %0d index %0d count %0d",
                           $realtime, rsp_data.status, rsp_data.index, rsp_data.count);
            end else begin
               want = pending_stack_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.index !== want.index ||
                   rsp_data.count !== want.count) begin
                  bad_count++;
                  if (bad_count <= REPORT_LIMIT)
                     $display("[%0t] response mismatch: expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
                              $realtime, want.status, want.index, want.count,
                              rsp_data.status, rsp_data.index, rsp_data.count);
               end
            end
         end
         if (req_valid && !req_stall)
            pending_stack_results.push_back(apply_stack_op(req_data));
      end
      waiting_count = pending_stack_results.size();
   end

endmodule

@@ tb/bounded_stack_with_search_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the bounded stack with search testbench: clock, reset, request and
// response stall stimulus and the verdict. Depends on bstk_pkg, the block
// and stack_response_checker.
module bounded_stack_with_search_core_tb;
   import bstk_pkg::*;

   // The package names three operations; the fourth code must act as a
   // no-op, so it gets a name of its own here.
   localparam logic [FUNC_W-1:0] OP_SPARE = 2'd3;

   // Length of the one long receiver hold, in clock cycles. It is far longer
   // than a full scan, so the block ends up holding a finished response and
   // stalls its request side.
   localparam int LONG_HOLD = 400;

   // Cycles to wait after the last response, enough for a full scan of a
   // full stack, so that a stray late response would still be seen.
   localparam int SETTLE_CYCLES = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int checked;

   // Idle controls, set by the stimulus process and read by the drivers.
   bit req_idle_on  = 1'b0;
   bit rsp_idle_on  = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;

   // Stimulus memory: the most recent pushed word, so that a find can look
   // for an entry that sits deep in the stack.
   logic [WORD_W-1:0] last_pushed = '0;

   int n_push  = 0;
   int n_pop   = 0;
   int n_find  = 0;
   int n_spare = 0;

   bounded_stack_with_search_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   stack_response_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run. It is several times what a correct run needs,
   // even with every request a full scan behind the longest stalls.
   initial begin
      #40_000_000;
      $display("bounded_stack_with_search_core_tb: FAIL");
      $finish;
   end

   // Idle lengths: one draw in ten takes the long range, the rest the short one.
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      return $urandom_range(1, 3);
   endfunction

   // Words that are pushed and searched for often, so that finds hit, and
   // that cover the sign boundaries.
   function automatic logic [WORD_W-1:0] common_word(input int k);
      case (k)
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'h0000_0001;
         5:       return 32'h0000_0002;
         6:       return 32'hFFFF_FFFE;
         default: return 32'h0000_0003;
      endcase
   endfunction

   // The receiver drives rsp_stall at the falling edge. When asked, it holds
   // off once for the long hold; otherwise, when idling is on, it stalls
   // for random stretches.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat (idle_length()) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one request and returns at the falling edge after its transfer.
   // While stalled, valid and the payload stay as they are.
   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] v);
      req_type r;
      int      gap;
      r.func  = f;
      r.value = v;
      if (req_idle_on && $urandom_range(0, 2) == 0) begin
         gap = idle_length();
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      case (f)
         OP_PUSH: n_push++;
         OP_POP:  n_pop++;
         OP_FIND: n_find++;
         default: n_spare++;
      endcase
   endtask

   // The sender pauses until every predicted response has come back.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // A random mix of operations. Percentages choose push, pop and find; what
   // is left goes to the spare code. Half the pushes use common words, finds
   // look for common words, the latest pushed word or a random word.
   task automatic run_mix(input int n, input int push_pct, input int pop_pct,
                          input int find_pct);
      int                k;
      int                roll;
      logic [FUNC_W-1:0] f;
      logic [WORD_W-1:0] v;
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         v    = $urandom;
         if (roll < push_pct) begin
            f = OP_PUSH;
            if ($urandom_range(0, 1) == 0) v = common_word($urandom_range(0, 7));
            last_pushed = v;
         end else if (roll < push_pct + pop_pct) begin
            f = OP_POP;
         end else if (roll < push_pct + pop_pct + find_pct) begin
            f    = OP_FIND;
            roll = $urandom_range(0, 9);
            if (roll < 4) v = common_word($urandom_range(0, 7));
            else if (roll < 7) v = last_pushed;
         end else begin
            f = OP_SPARE;
         end
         send_request(f, v);
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: operations on an empty stack, the word extremes,
      // a duplicate entry so that find must report the lowest position,
      // a miss, the spare code, and a drain back to empty.
      send_request(OP_POP,   32'h1234_5678);
      send_request(OP_FIND,  32'h0000_0000);
      send_request(OP_SPARE, 32'hFFFF_FFFF);
      send_request(OP_PUSH,  32'h7FFF_FFFF);
      send_request(OP_PUSH,  32'h8000_0000);
      send_request(OP_PUSH,  32'h0000_0000);
      send_request(OP_PUSH,  32'hFFFF_FFFF);
      send_request(OP_PUSH,  32'h8000_0000);
      send_request(OP_FIND,  32'h8000_0000);
      send_request(OP_FIND,  32'hFFFF_FFFF);
      send_request(OP_FIND,  32'h7FFF_FFFF);
      send_request(OP_FIND,  32'h0000_3039);
      send_request(OP_SPARE, 32'h0000_0000);
      send_request(OP_POP,   32'h0000_0000);
      send_request(OP_FIND,  32'hFFFF_FFFF);
      send_request(OP_FIND,  32'h8000_0000);
      repeat (4) send_request(OP_POP, 32'hA5A5_A5A5);
      send_request(OP_POP,   32'h5A5A_5A5A);
      send_request(OP_FIND,  32'h0000_0000);
      wait_for_responses();

      // Fill phase, idling on both sides. The receiver's long hold starts
      // right away while requests keep coming, so the block backs up. The
      // stack reaches capacity and further pushes are refused.
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      hold_request = 1'b1;
      run_mix(400, 85, 3, 10);
      wait_for_responses();

      // Drain phase: mostly pops, down to empty and past it.
      run_mix(400, 8, 80, 10);
      wait_for_responses();

      // Balanced phase with no idling at all, back to back transfers.
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_mix(400, 45, 35, 18);
      wait_for_responses();

      // Search-heavy phase with idling back on.
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      run_mix(400, 30, 20, 48);
      wait_for_responses();

      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d requests (%0d push, %0d pop, %0d find, %0d spare code),",
               n_push + n_pop + n_find + n_spare, n_push, n_pop, n_find, n_spare);
      $display("%0d responses checked; the stack was filled past capacity and drained",
               checked);
      $display("past empty under random stalls.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("bounded_stack_with_search_core_tb: PASS");
      end else begin
         $display("bounded_stack_with_search_core_tb: FAIL");
      end
      $finish;
   end

endmodule
